// ===== rtl/core/ritd_pkg.sv =====
// Shared types, register indexes and a helper function of the radix integer-to-digits core.
`default_nettype none

package ritd_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned BASE_LEN_W = 5;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned IN_VALUE_W = 64;

  // Register contents after reset: radix ten and the lower-case hex alphabet.
  localparam logic [BASE_LEN_W-1:0] BASE_LEN_RST   = 5'd10;
  localparam logic [CFG_DATA_W-1:0] CHARS_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] CHARS_HIGH_RST = 64'h6665_6463_6261_3938;

  typedef struct packed {
    logic                  cmd;
    logic [IN_VALUE_W-1:0] value;
  } ritd_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              negative;
    logic              last;
  } ritd_out_t;

  // Status from the serial divider to the sequencer.
  typedef struct packed {
    logic               digit_vld;
    logic [DIGIT_W-1:0] digit;
    logic               final_digit;
  } ritd_div_stat_t;

  // Picks the character of one digit out of the two table registers.
  function automatic logic [CHAR_W-1:0] char_of_digit(
    input logic [CFG_DATA_W-1:0] chars_low,
    input logic [CFG_DATA_W-1:0] chars_high,
    input logic [DIGIT_W-1:0]    digit
  );
    logic [2*CFG_DATA_W-1:0] tbl;
    tbl = {chars_high, chars_low};
    return tbl[{digit, 3'b000} +: CHAR_W];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ritd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ritd_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/ritd_div_serial.sv =====
// Bit-serial restoring divider that peels off one digit per pass over the magnitude bits.
`default_nettype none

module ritd_div_serial #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [VALUE_BITS-1:0]             magnitude,
  input  wire logic [ritd_pkg::BASE_LEN_W-1:0]   radix,
  output ritd_pkg::ritd_div_stat_t               stat
);

  import ritd_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [CW-1:0]         bit_r, bit_nxt;
  logic                  busy_r, busy_nxt;

  logic [DIGIT_W:0]      rem_sh;
  logic [DIGIT_W:0]      rem_new;
  logic                  ge;
  logic [VALUE_BITS-1:0] quot;
  logic                  last_bit;
  logic                  quot_zero;

  // The partial remainder stays below the radix, so one compare and subtract suffices.
  always_comb begin
    rem_sh    = {rem_r, mag_r[VALUE_BITS-1]};
    ge        = (rem_sh >= radix);
    rem_new   = ge ? (rem_sh - radix) : rem_sh;
    quot      = {mag_r[VALUE_BITS-2:0], ge};
    last_bit  = (bit_r == '0);
    quot_zero = (quot == '0);
  end

  always_comb begin
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    if (start) begin
      mag_nxt  = magnitude;
      rem_nxt  = '0;
      bit_nxt  = CW'(VALUE_BITS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      mag_nxt = quot;
      if (last_bit) begin
        rem_nxt  = '0;
        bit_nxt  = CW'(VALUE_BITS - 1);
        busy_nxt = !quot_zero;
      end else begin
        rem_nxt = rem_new[DIGIT_W-1:0];
        bit_nxt = bit_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
  end

  assign stat.digit_vld   = busy_r && last_bit;
  assign stat.digit       = rem_new[DIGIT_W-1:0];
  assign stat.final_digit = quot_zero;

endmodule

`default_nettype wire

// ===== rtl/core/radix_integer_to_digits_core.sv =====
// Top level of the radix integer-to-digits core: sequencer, configuration and result register.
`default_nettype none

// The core turns one integer into its digits in a radix between 2 and MAX_RADIX and
// delivers them as one output transaction per digit, most significant first, each
// carrying the digit's character from the configured table, the sign flag of the
// input and a marker on the final digit. Only the low VALUE_BITS bits of the input
// value are used. Every digit comes out of the bit-serial divider, which shifts in
// one bit of the magnitude per cycle, and is then read back from the digit RAM.
// One conversion is in flight at a time: a new input transaction is taken once the
// final digit has moved into the output register, even while that digit still waits
// for the consumer. Configuration must only be written while the core is idle.

module radix_integer_to_digits_core #(
  parameter int unsigned MAX_RADIX  = 16,
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire ritd_pkg::ritd_in_t              in_data,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output ritd_pkg::ritd_out_t                  out_data,
  // Configuration port
  input  wire logic                            cfg_wr_en,
  input  wire logic [ritd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ritd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import ritd_pkg::*;

  localparam int unsigned AW = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD
  } state_t;

  // Configuration registers.
  logic [BASE_LEN_W-1:0] base_len_r;
  logic [CFG_DATA_W-1:0] chars_low_r;
  logic [CFG_DATA_W-1:0] chars_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_len_r   <= BASE_LEN_RST;
      chars_low_r  <= CHARS_LOW_RST;
      chars_high_r <= CHARS_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BASE_LEN:   base_len_r   <= cfg_wdata[BASE_LEN_W-1:0];
        REG_CHARS_LOW:  chars_low_r  <= cfg_wdata;
        REG_CHARS_HIGH: chars_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Radices below two act as two, those above the maximum as the maximum.
  logic [BASE_LEN_W-1:0] radix;

  always_comb begin
    priority if (base_len_r < BASE_LEN_W'(2)) begin
      radix = BASE_LEN_W'(2);
    end else if (base_len_r > BASE_LEN_W'(MAX_RADIX)) begin
      radix = BASE_LEN_W'(MAX_RADIX);
    end else begin
      radix = base_len_r;
    end
  end

  // A negative signed input is converted as its two's complement magnitude; the most
  // negative value yields 2^(VALUE_BITS-1), which still fits the unsigned register.
  logic [VALUE_BITS-1:0] in_value;
  logic                  in_negative;
  logic [VALUE_BITS-1:0] in_magnitude;

  always_comb begin
    in_value     = in_data.value[VALUE_BITS-1:0];
    in_negative  = in_data.cmd && in_value[VALUE_BITS-1];
    in_magnitude = in_negative ? (VALUE_BITS'(0) - in_value) : in_value;
  end

  state_t state_r;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Serial divider: produces digits least significant first.
  ritd_div_stat_t div_stat;

  ritd_div_serial #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .magnitude (in_magnitude),
    .radix     (radix),
    .stat      (div_stat)
  );

  // Digit RAM: entry 0 holds the least significant digit. Every entry that is read
  // back has been written during the same conversion, so it needs no clearing.
  logic [AW-1:0]      wptr_r;
  logic [AW-1:0]      rptr_r;
  logic [DIGIT_W-1:0] ram_rdata;
  logic               ram_we;

  assign ram_we = (state_r == ST_DIV) && div_stat.digit_vld;

  ritd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (div_stat.digit),
    .raddr (rptr_r),
    .rdata (ram_rdata)
  );

  // The output register frees up when its transaction completes, so a new digit
  // can be loaded while the old one is taken.
  logic      neg_r;
  logic      out_valid_r;
  ritd_out_t out_data_r;
  logic      out_free;
  logic      load;

  assign out_free = !out_valid_r || out_ready;
  assign load     = (state_r == ST_LOAD) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.digit_vld && div_stat.final_digit) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          if (load) begin
            state_r <= (rptr_r == '0) ? ST_IDLE : ST_READ;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    // Pointers and payload carry no reset; the state machine qualifies them.
    if (accept) begin
      neg_r  <= in_negative;
      wptr_r <= '0;
    end

    if (ram_we) begin
      if (div_stat.final_digit) begin
        rptr_r <= wptr_r;
      end else begin
        wptr_r <= wptr_r + AW'(1);
      end
    end

    if (load) begin
      out_data_r.digit_char <= char_of_digit(chars_low_r, chars_high_r, ram_rdata);
      out_data_r.negative   <= neg_r;
      out_data_r.last       <= (rptr_r == '0);
      if (rptr_r != '0) begin
        rptr_r <= rptr_r - AW'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
